>>> src/lnf_pkg.sv
// Shared constants, payload structs and controller/datapath signal groups
// for the layer normalization forward core. No dependencies.
package lnf_pkg;

    localparam int DATA_W       = 24;
    localparam int FRAC_W       = 16;
    localparam int MAX_FEATURES = 4096;
    localparam int CNT_W        = 13;
    localparam int EPS_W        = 32;
    localparam int RSTD_W       = 32;
    localparam int SUM_W        = 37;
    localparam int SQS_W        = 60;
    localparam int MEAN_MAG_W   = 36;
    localparam int DVD_W        = 65;
    localparam int DVS_W        = 61;
    localparam int ITER_W       = 7;
    localparam int DIV_STEPS    = 65;
    localparam int SQRT_STEPS   = 32;
    localparam int CFG_IDX_W    = 8;

    localparam logic [CNT_W-1:0] FC_RESET  = 13'd4096;
    localparam logic [EPS_W-1:0] EPS_RESET = 32'd42950;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_EPSILON = 8'd1;

    localparam logic [1:0] DIV_SEL_MEAN = 2'd0;
    localparam logic [1:0] DIV_SEL_EX2  = 2'd1;
    localparam logic [1:0] DIV_SEL_Q    = 2'd2;

    localparam logic KIND_STATS = 1'b0;
    localparam logic KIND_NORM  = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] gamma;
        logic signed [DATA_W-1:0] beta;
    } t_in_item;

    typedef struct packed {
        logic                     result_kind;
        logic signed [DATA_W-1:0] y_value;
        logic signed [DATA_W-1:0] row_mean;
        logic [RSTD_W-1:0]        row_rstd;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic       capture;
        logic       acc;
        logic       div_load;
        logic [1:0] div_sel;
        logic       div_step;
        logic       mean_cap;
        logic       sqr;
        logic       m2;
        logic       var_calc;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       fin;
        logic       n1;
        logic       n2;
        logic       n3;
        logic       n4;
        logic       n5;
        logic       out_norm;
    } t_cmd;

    typedef struct packed {
        logic in_func;
        logic row_last;
        logic div_last;
        logic sqrt_last;
        logic v_small;
        logic out_free;
    } t_sts;

endpackage

>>> src/layer_norm_forward_core.sv
// Top level of the layer normalization forward core.
// Depends on lnf_pkg, lnf_ctrl and lnf_datapath.
//
// Input items arrive on i_in_valid/o_in_ready with an lnf_pkg::t_in_item
// payload; results leave on o_out_valid/i_out_ready as lnf_pkg::t_out_item.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index and
// data; the port is always ready and unknown indexes are ignored.
// A statistics element is added to the row sums and gives no result, except
// the last element of a row, which runs two 65-step divisions on the shared
// divider and, unless variance plus epsilon is at most one, a third 65-step
// division and a 32-step square root before its result is delivered. A
// normalize element passes a six-step multiply chain. One item is in work at
// a time, so a new item is taken only once the last one is through. A finished
// result waits in the output register while the next item is taken; if the
// receiver stalls, the following result holds the block until the register
// frees. Synchronous reset clears the sums, the stored statistics and the
// output valid flag, and loads the default configuration.
module layer_norm_forward_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lnf_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lnf_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lnf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lnf_pkg::EPS_W-1:0]     i_cfg_data
);

    lnf_pkg::t_cmd w_cmd;
    lnf_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lnf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_stat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == lnf_pkg::KIND_STATS &&
         o_out_data.saturated) |-> (o_out_data.row_rstd == '1))
        else $error("clipped statistics result without full-scale rstd");

    a_stat_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == lnf_pkg::KIND_STATS)
        |-> (o_out_data.y_value == '0))
        else $error("statistics result carries a nonzero element value");

endmodule

>>> src/lnf_ctrl.sv
// Sequencing state machine of the layer normalization core.
// Depends on lnf_pkg for the command and status groups.
module lnf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lnf_pkg::t_sts i_sts,
    output lnf_pkg::t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ACC      = 5'd1;
    localparam logic [4:0] S_LD_MEAN  = 5'd2;
    localparam logic [4:0] S_DIV_MEAN = 5'd3;
    localparam logic [4:0] S_LD_EX2   = 5'd4;
    localparam logic [4:0] S_DIV_EX2  = 5'd5;
    localparam logic [4:0] S_SQR      = 5'd6;
    localparam logic [4:0] S_M2       = 5'd7;
    localparam logic [4:0] S_VAR      = 5'd8;
    localparam logic [4:0] S_CHK      = 5'd9;
    localparam logic [4:0] S_DIV_Q    = 5'd10;
    localparam logic [4:0] S_LD_SQRT  = 5'd11;
    localparam logic [4:0] S_SQRT     = 5'd12;
    localparam logic [4:0] S_FIN      = 5'd13;
    localparam logic [4:0] S_N1       = 5'd14;
    localparam logic [4:0] S_N2       = 5'd15;
    localparam logic [4:0] S_N3       = 5'd16;
    localparam logic [4:0] S_N4       = 5'd17;
    localparam logic [4:0] S_N5       = 5'd18;
    localparam logic [4:0] S_N6       = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_sts.in_func ? S_N1 : S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_sts.row_last ? S_LD_MEAN : S_IDLE;
            end
            S_LD_MEAN: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = lnf_pkg::DIV_SEL_MEAN;
                n_state = S_DIV_MEAN;
            end
            S_DIV_MEAN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LD_EX2;
                end
            end
            S_LD_EX2: begin
                o_cmd.mean_cap = 1'b1;
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = lnf_pkg::DIV_SEL_EX2;
                n_state = S_DIV_EX2;
            end
            S_DIV_EX2: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.m2 = 1'b1;
                n_state = S_VAR;
            end
            S_VAR: begin
                o_cmd.var_calc = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.v_small) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = lnf_pkg::DIV_SEL_Q;
                    n_state = S_DIV_Q;
                end
            end
            S_DIV_Q: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LD_SQRT;
                end
            end
            S_LD_SQRT: begin
                o_cmd.sqrt_load = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_N1: begin
                o_cmd.n1 = 1'b1;
                n_state = S_N2;
            end
            S_N2: begin
                o_cmd.n2 = 1'b1;
                n_state = S_N3;
            end
            S_N3: begin
                o_cmd.n3 = 1'b1;
                n_state = S_N4;
            end
            S_N4: begin
                o_cmd.n4 = 1'b1;
                n_state = S_N5;
            end
            S_N5: begin
                o_cmd.n5 = 1'b1;
                n_state = S_N6;
            end
            S_N6: begin
                if (i_sts.out_free) begin
                    o_cmd.out_norm = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/lnf_datapath.sv
// Datapath of the layer normalization core: configuration, row sums, shared
// restoring divider, digit-recurrence square root, normalize multipliers and
// the output register. Depends on lnf_pkg.
module lnf_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lnf_pkg::t_cmd                     i_cmd,
    output lnf_pkg::t_sts                     o_sts,
    input  lnf_pkg::t_in_item                 i_in_data,
    input  logic                              i_cfg_valid,
    input  logic [lnf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lnf_pkg::EPS_W-1:0]         i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lnf_pkg::t_out_item                o_out_data
);

    localparam int D_W = lnf_pkg::SUM_W + 1;
    localparam int Y_W = 50;
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((2 ** (lnf_pkg::DATA_W - 1)) - 1);
    localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

    logic [lnf_pkg::CNT_W-1:0]         r_fc;
    logic [lnf_pkg::EPS_W-1:0]         r_eps;
    logic signed [lnf_pkg::SUM_W-1:0]  r_vsum;
    logic [lnf_pkg::SQS_W-1:0]         r_sqsum;
    logic [lnf_pkg::CNT_W-1:0]         r_count;
    logic signed [lnf_pkg::SUM_W-1:0]  r_mean;
    logic [lnf_pkg::RSTD_W-1:0]        r_rstd;
    logic                              r_out_valid;

    logic signed [lnf_pkg::DATA_W-1:0] r_x;
    logic signed [lnf_pkg::DATA_W-1:0] r_g;
    logic signed [lnf_pkg::DATA_W-1:0] r_b;
    logic [lnf_pkg::DVD_W-1:0]         r_dvd;
    logic [lnf_pkg::DVD_W-1:0]         r_quo;
    logic [lnf_pkg::DVS_W-1:0]         r_dvs;
    logic [lnf_pkg::DVS_W-1:0]         r_rem;
    logic [lnf_pkg::ITER_W-1:0]        r_iter;
    logic [lnf_pkg::MEAN_MAG_W-1:0]    r_mean_mag;
    logic [63:0]                       r_ex2;
    logic [63:0]                       r_m2;
    logic [lnf_pkg::DVS_W-1:0]         r_v;
    logic [63:0]                       r_rad;
    logic [33:0]                       r_srem;
    logic [31:0]                       r_root;
    logic [63:0]                       r_pa;
    logic [39:0]                       r_pb;
    logic [D_W-2:0]                    r_dmag;
    logic                              r_dneg;
    logic [lnf_pkg::DATA_W-1:0]        r_gmag;
    logic                              r_gneg;
    logic [47:0]                       r_nmag;
    logic [47:0]                       r_cmag;
    lnf_pkg::t_out_item                r_out;

    logic [lnf_pkg::CNT_W-1:0]         w_c;
    logic signed [2*lnf_pkg::DATA_W-1:0] w_xsq;
    logic [lnf_pkg::SUM_W-1:0]         w_sum_mag;
    logic [lnf_pkg::DVD_W-1:0]         w_half_c;
    logic [lnf_pkg::DVS_W:0]           w_trial;
    logic [lnf_pkg::DVS_W:0]           w_tdiff;
    logic                              w_ge;
    logic [33:0]                       w_strial;
    logic [33:0]                       w_stest;
    logic                              w_sge;
    logic [63:0]                       w_var;
    logic signed [lnf_pkg::SUM_W-1:0]  w_mean_s;
    logic signed [D_W-1:0]             w_d;
    logic [63:0]                       w_rnd;
    logic [Y_W-1:0]                    w_cs;
    logic signed [Y_W-1:0]             w_y;
    logic                              w_ysat;
    logic                              w_out_load;

    always_comb begin
        if (r_fc == '0) begin
            w_c = lnf_pkg::CNT_W'(1);
        end else if (r_fc > lnf_pkg::CNT_W'(lnf_pkg::MAX_FEATURES)) begin
            w_c = lnf_pkg::CNT_W'(lnf_pkg::MAX_FEATURES);
        end else begin
            w_c = r_fc;
        end
    end

    assign w_xsq     = (2*lnf_pkg::DATA_W)'(r_x) * (2*lnf_pkg::DATA_W)'(r_x);
    assign w_sum_mag = r_vsum[lnf_pkg::SUM_W-1] ? $unsigned(-r_vsum) : $unsigned(r_vsum);
    assign w_half_c  = lnf_pkg::DVD_W'(w_c >> 1);
    assign w_trial   = {r_rem, r_dvd[lnf_pkg::DVD_W-1]};
    assign w_tdiff   = w_trial - {1'b0, r_dvs};
    assign w_ge      = (w_trial >= {1'b0, r_dvs});
    assign w_strial  = {r_srem[31:0], r_rad[63:62]};
    assign w_stest   = {r_root, 2'b01};
    assign w_sge     = (w_strial >= w_stest);
    assign w_var     = (r_ex2 > r_m2) ? (r_ex2 - r_m2) : 64'd0;
    assign w_mean_s  = r_vsum[lnf_pkg::SUM_W-1] ? -$signed({1'b0, r_mean_mag})
                                                 : $signed({1'b0, r_mean_mag});
    assign w_d       = D_W'(r_x) - D_W'(r_mean);
    assign w_rnd     = r_pa + {r_pb[31:0], 32'd0} + 64'(2 ** (lnf_pkg::FRAC_W - 1));
    assign w_cs      = (r_dneg ^ r_gneg) ? -{2'b00, r_cmag} : {2'b00, r_cmag};
    assign w_y       = $signed(w_cs) + Y_W'(r_b);
    assign w_ysat    = (w_y > Y_MAX) || (w_y < Y_MIN);
    assign w_out_load = i_cmd.fin || i_cmd.out_norm;

    assign o_sts.in_func   = i_in_data.func;
    assign o_sts.row_last  = ({1'b0, r_count} + 1'b1) >= {1'b0, w_c};
    assign o_sts.div_last  = (r_iter == lnf_pkg::ITER_W'(lnf_pkg::DIV_STEPS - 1));
    assign o_sts.sqrt_last = (r_iter == lnf_pkg::ITER_W'(lnf_pkg::SQRT_STEPS - 1));
    assign o_sts.v_small   = (r_v <= lnf_pkg::DVS_W'(1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc        <= lnf_pkg::FC_RESET;
            r_eps       <= lnf_pkg::EPS_RESET;
            r_vsum      <= '0;
            r_sqsum     <= '0;
            r_count     <= '0;
            r_mean      <= '0;
            r_rstd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lnf_pkg::CFG_FEATURE_COUNT:    r_fc  <= i_cfg_data[lnf_pkg::CNT_W-1:0];
                    lnf_pkg::CFG_VARIANCE_EPSILON: r_eps <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.acc) begin
                r_vsum  <= r_vsum + lnf_pkg::SUM_W'(r_x);
                r_sqsum <= r_sqsum + {(lnf_pkg::SQS_W - 2*lnf_pkg::DATA_W)'(0), w_xsq};
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.fin) begin
                r_mean  <= w_mean_s;
                r_rstd  <= o_sts.v_small ? '1 : r_root;
                r_vsum  <= '0;
                r_sqsum <= '0;
                r_count <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= i_in_data.x_value;
            r_g <= i_in_data.gamma;
            r_b <= i_in_data.beta;
        end
        if (i_cmd.div_load) begin
            r_iter <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
            case (i_cmd.div_sel)
                lnf_pkg::DIV_SEL_MEAN: begin
                    r_dvd <= lnf_pkg::DVD_W'(w_sum_mag) + w_half_c;
                    r_dvs <= lnf_pkg::DVS_W'(w_c);
                end
                lnf_pkg::DIV_SEL_EX2: begin
                    r_dvd <= lnf_pkg::DVD_W'(r_sqsum) + w_half_c;
                    r_dvs <= lnf_pkg::DVS_W'(w_c);
                end
                default: begin
                    r_dvd <= {1'b1, (lnf_pkg::DVD_W-1)'(0)};
                    r_dvs <= r_v;
                end
            endcase
        end
        if (i_cmd.div_step) begin
            r_iter <= r_iter + 1'b1;
            r_rem  <= w_ge ? w_tdiff[lnf_pkg::DVS_W-1:0] : w_trial[lnf_pkg::DVS_W-1:0];
            r_quo  <= {r_quo[lnf_pkg::DVD_W-2:0], w_ge};
            r_dvd  <= {r_dvd[lnf_pkg::DVD_W-2:0], 1'b0};
        end
        if (i_cmd.mean_cap) begin
            r_mean_mag <= r_quo[lnf_pkg::MEAN_MAG_W-1:0];
        end
        if (i_cmd.sqr) begin
            r_ex2 <= r_quo[63:0];
            r_pa  <= 64'(r_mean_mag[31:0]) * 64'(r_mean_mag[31:0]);
            r_pb  <= 40'(r_mean_mag[lnf_pkg::MEAN_MAG_W-1:32]) * 40'(r_mean_mag[31:0]);
        end
        if (i_cmd.m2) begin
            r_m2 <= r_pa + {r_pb[30:0], 1'b0, 32'd0};
        end
        if (i_cmd.var_calc) begin
            r_v <= w_var[lnf_pkg::DVS_W-1:0] + lnf_pkg::DVS_W'(r_eps);
        end
        if (i_cmd.sqrt_load) begin
            r_iter <= '0;
            r_rad  <= r_quo[63:0];
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_iter <= r_iter + 1'b1;
            r_srem <= w_sge ? (w_strial - w_stest) : w_strial;
            r_root <= {r_root[30:0], w_sge};
            r_rad  <= {r_rad[61:0], 2'b00};
        end
        if (i_cmd.n1) begin
            r_dneg <= w_d[D_W-1];
            r_dmag <= w_d[D_W-1] ? (D_W-1)'($unsigned(-w_d)) : $unsigned(w_d[D_W-2:0]);
            r_gneg <= r_g[lnf_pkg::DATA_W-1];
            r_gmag <= r_g[lnf_pkg::DATA_W-1] ? $unsigned(-r_g) : $unsigned(r_g);
        end
        if (i_cmd.n2) begin
            r_pa <= 64'(r_dmag[31:0]) * 64'(r_rstd);
            r_pb <= 40'(r_dmag[D_W-2:32]) * 40'(r_rstd);
        end
        if (i_cmd.n3) begin
            r_nmag <= w_rnd[63:16];
        end
        if (i_cmd.n4) begin
            r_pa <= 64'(r_nmag[31:0]) * 64'(r_gmag);
            r_pb <= 40'(r_nmag[47:32]) * 40'(r_gmag);
        end
        if (i_cmd.n5) begin
            r_cmag <= w_rnd[63:16];
        end
        if (i_cmd.fin) begin
            r_out.result_kind <= lnf_pkg::KIND_STATS;
            r_out.y_value     <= '0;
            r_out.row_mean    <= w_mean_s[lnf_pkg::DATA_W-1:0];
            r_out.row_rstd    <= o_sts.v_small ? '1 : r_root;
            r_out.saturated   <= o_sts.v_small;
        end
        if (i_cmd.out_norm) begin
            r_out.result_kind <= lnf_pkg::KIND_NORM;
            if (w_y > Y_MAX) begin
                r_out.y_value <= Y_MAX[lnf_pkg::DATA_W-1:0];
            end else if (w_y < Y_MIN) begin
                r_out.y_value <= Y_MIN[lnf_pkg::DATA_W-1:0];
            end else begin
                r_out.y_value <= w_y[lnf_pkg::DATA_W-1:0];
            end
            r_out.row_mean    <= r_mean[lnf_pkg::DATA_W-1:0];
            r_out.row_rstd    <= r_rstd;
            r_out.saturated   <= w_ysat;
        end
    end

endmodule
